// ===== hdl/bmw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmw_pkg
// Types, codes and the logical block decoder shared by the block-map walker.
// ----------------------------------------------------------------------------
package bmw_pkg;

  localparam int DIRECT_COUNT = 12;
  localparam int SLOT_SINGLE  = 12;
  localparam int SLOT_DOUBLE  = 13;
  localparam int SLOT_COUNT   = 14;
  localparam int LB_W         = 22;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = 10;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_XLATE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_ANSWER = 2'd0,
    KIND_READ   = 2'd1,
    KIND_FAIL   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_XLATE = 2'd1,
    OP_FILL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_DIRECT = 2'd0,
    REG_SINGLE = 2'd1,
    REG_DOUBLE = 2'd2,
    REG_FAIL   = 2'd3
  } region_t;

  typedef struct packed {
    region_t            region;
    logic [IDX_W-1:0]   index;   // direct slot, single entry or root entry
    logic [IDX_W-1:0]   second;  // leaf entry
  } dec_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         slot;
    logic [WORD_W-1:0]  value;
    logic               err;
    logic [LB_W-1:0]    lb;
    dec_t               dec;
  } item_t;

  function automatic dec_t decode(logic [LB_W-1:0] lb, logic [1:0] lbs, logic unsup);
    dec_t             d;
    logic [LB_W-1:0]  epb;
    logic [LB_W-1:0]  idx;
    logic [LB_W-1:0]  idx2;
    epb  = LB_W'(256) << lbs;
    idx  = lb - LB_W'(DIRECT_COUNT);
    idx2 = idx - epb;
    d.region = REG_FAIL;
    d.index  = lb[IDX_W-1:0];
    d.second = '0;
    if (lb < LB_W'(DIRECT_COUNT)) begin
      d.region = REG_DIRECT;
    end else if (unsup) begin
      d.region = REG_FAIL;
    end else if (idx < epb) begin
      d.region = REG_SINGLE;
      d.index  = idx[IDX_W-1:0];
    end else if ((idx2 >> (16 + 2 * int'(lbs))) != '0) begin
      d.region = REG_FAIL;
    end else begin
      d.region = REG_DOUBLE;
      d.index  = IDX_W'(idx2 >> (8 + int'(lbs)));
      d.second = IDX_W'(idx2 & (epb - LB_W'(1)));
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bmw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmw_queue
// Four-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bmw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bmw_pkg::item_t push_item,
  output logic               full,
  output logic               not_empty,
  input  wire logic          pop,
  output bmw_pkg::item_t     head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  bmw_pkg::item_t  entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + PW'(1);
      if (pop && not_empty) rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && not_empty);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bmw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmw_front
// Accept input items, drop meaningless ones, decode logical blocks, enqueue.
// ----------------------------------------------------------------------------
module bmw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    command,
  input  wire logic [3:0]    slot,
  input  wire logic [21:0]   file_block,
  input  wire logic [31:0]   value,
  input  wire logic          read_error,
  input  wire logic [1:0]    lbs,
  input  wire logic          unsup,
  output logic               push,
  output bmw_pkg::item_t     push_item,
  input  wire logic          q_full
);

  logic            stage_valid;
  bmw_pkg::item_t  stage;
  bmw_pkg::item_t  stage_next;
  logic            keep;
  logic            accept;

  assign in_stall  = stage_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = stage_valid && !q_full;
  assign push_item = stage;

  always_comb begin
    stage_next.slot  = slot;
    stage_next.value = value;
    stage_next.err   = read_error;
    stage_next.lb    = file_block;
    stage_next.dec   = bmw_pkg::decode(file_block, lbs, unsup);
    stage_next.op    = bmw_pkg::OP_LOAD;
    keep             = 1'b0;
    case (command)
      bmw_pkg::CMD_LOAD: begin
        keep = (slot < 4'(bmw_pkg::SLOT_COUNT));
      end
      bmw_pkg::CMD_XLATE: begin
        stage_next.op = bmw_pkg::OP_XLATE;
        keep          = 1'b1;
      end
      bmw_pkg::CMD_FILL: begin
        stage_next.op = bmw_pkg::OP_FILL;
        keep          = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) stage <= stage_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= keep;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bmw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmw_back
// Pointer table, three block caches, fill sequencing and result register.
// ----------------------------------------------------------------------------
module bmw_back #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire bmw_pkg::item_t q_item,
  output logic               q_pop,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_data,
  output logic [1:0]         lbs,
  output logic               unsup,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         kind,
  output logic [31:0]        phys_block
);

  localparam int AW = $clog2(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_TRANS, S_RD_SINGLE, S_RD_ROOT, S_RD_LEAF
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_SINGLE, PH_ROOT, PH_LEAF
  } phase_t;

  state_t                 state;
  phase_t                 phase;
  logic [31:0]            ptab [bmw_pkg::SLOT_COUNT];
  logic [31:0]            single_mem [MAX_ENTRIES];
  logic [31:0]            root_mem   [MAX_ENTRIES];
  logic [31:0]            leaf_mem   [MAX_ENTRIES];
  logic [31:0]            single_rdata, root_rdata, leaf_rdata;
  logic [31:0]            single_tag, root_tag, leaf_tag;
  logic                   single_ok, root_valid, leaf_valid;
  logic [AW-1:0]          fill_count;
  logic [21:0]            pending;
  logic [21:0]            cur_lb;
  bmw_pkg::dec_t          cur_dec;
  bmw_pkg::kind_t         kind_r;
  logic [31:0]            bn_r;
  logic                   can_emit;
  logic [10:0]            epb;
  logic [AW-1:0]          last_idx;
  logic                   fill_we;
  logic                   fill_last;
  logic [31:0]            ptr_s, ptr_d;

  assign cfg_ready    = 1'b1;
  assign epb          = 11'd256 << lbs;
  assign unsup        = (lbs == 2'd3) || (epb > 11'(MAX_ENTRIES));
  assign last_idx     = AW'(epb - 11'd1);
  assign can_emit     = !out_valid || !out_stall;
  assign q_pop        = (state == S_IDLE) && q_valid && can_emit;
  assign fill_we      = q_pop && (q_item.op == bmw_pkg::OP_FILL) && (phase != PH_IDLE)
                        && !q_item.err && !unsup;
  assign fill_last    = (fill_count == last_idx);
  assign ptr_s        = ptab[bmw_pkg::SLOT_SINGLE];
  assign ptr_d        = ptab[bmw_pkg::SLOT_DOUBLE];
  assign kind         = kind_r;
  assign phys_block   = bn_r;

  // Cache memories: write during fill, read continuously at the decoded index.
  always_ff @(posedge clk) begin
    if (fill_we && phase == PH_SINGLE) single_mem[fill_count] <= q_item.value;
    single_rdata <= single_mem[cur_dec.index[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fill_we && phase == PH_ROOT) root_mem[fill_count] <= q_item.value;
    root_rdata <= root_mem[cur_dec.index[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fill_we && phase == PH_LEAF) leaf_mem[fill_count] <= q_item.value;
    leaf_rdata <= leaf_mem[cur_dec.second[AW-1:0]];
  end

  always_ff @(posedge clk) begin : seq_main
    logic fire;
    fire = 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      lbs          <= 2'd0;
      single_ok    <= 1'b0;
      root_valid   <= 1'b0;
      leaf_valid   <= 1'b0;
      single_tag   <= '0;
      root_tag     <= '0;
      leaf_tag     <= '0;
      fill_count   <= '0;
      pending      <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < bmw_pkg::SLOT_COUNT; i++) ptab[i] <= '0;
    end else if (cfg_valid) begin
      lbs          <= cfg_data;
      single_ok    <= 1'b0;
      root_valid   <= 1'b0;
      leaf_valid   <= 1'b0;
      phase        <= PH_IDLE;
      fill_count   <= '0;
      state        <= S_IDLE;
    end else begin
      if (can_emit) begin
        case (state)
          S_IDLE: begin
            if (q_valid) begin
              case (q_item.op)
                bmw_pkg::OP_LOAD: begin
                  ptab[q_item.slot] <= q_item.value;
                end
                bmw_pkg::OP_XLATE: begin
                  if (phase != PH_IDLE) begin
                    fire   = 1'b1;
                    kind_r <= bmw_pkg::KIND_FAIL;
                    bn_r   <= '0;
                  end else begin
                    cur_lb  <= q_item.lb;
                    cur_dec <= q_item.dec;
                    state   <= S_TRANS;
                  end
                end
                bmw_pkg::OP_FILL: begin
                  if (phase != PH_IDLE) begin
                    if (q_item.err || unsup) begin
                      // abort: leave the cache invalid
                      case (phase)
                        PH_SINGLE: single_ok    <= 1'b0;
                        PH_ROOT:   root_valid   <= 1'b0;
                        default:   leaf_valid   <= 1'b0;
                      endcase
                      phase      <= PH_IDLE;
                      fill_count <= '0;
                      fire       = 1'b1;
                      kind_r     <= bmw_pkg::KIND_FAIL;
                      bn_r       <= '0;
                    end else if (fill_last) begin
                      case (phase)
                        PH_SINGLE: single_ok    <= 1'b1;
                        PH_ROOT:   root_valid   <= 1'b1;
                        default:   leaf_valid   <= 1'b1;
                      endcase
                      phase      <= PH_IDLE;
                      fill_count <= '0;
                      cur_lb     <= pending;
                      cur_dec    <= bmw_pkg::decode(pending, lbs, unsup);
                      state      <= S_TRANS;
                    end else begin
                      fill_count <= fill_count + AW'(1);
                    end
                  end
                end
                default: ;
              endcase
            end
          end
          S_TRANS: begin
            case (cur_dec.region)
              bmw_pkg::REG_DIRECT: begin
                state  <= S_IDLE;
                fire   = 1'b1;
                kind_r <= bmw_pkg::KIND_ANSWER;
                bn_r   <= ptab[cur_dec.index[3:0]];
              end
              bmw_pkg::REG_SINGLE: begin
                if (ptr_s == '0) begin
                  state  <= S_IDLE;
                  fire   = 1'b1;
                  kind_r <= bmw_pkg::KIND_ANSWER;
                  bn_r   <= '0;
                end else if (single_ok && single_tag == ptr_s) begin
                  state <= S_RD_SINGLE;
                end else begin
                  state        <= S_IDLE;
                  single_tag   <= ptr_s;
                  single_ok    <= 1'b0;
                  phase        <= PH_SINGLE;
                  fill_count   <= '0;
                  pending      <= cur_lb;
                  fire         = 1'b1;
                  kind_r       <= bmw_pkg::KIND_READ;
                  bn_r         <= ptr_s;
                end
              end
              bmw_pkg::REG_DOUBLE: begin
                if (ptr_d == '0) begin
                  state  <= S_IDLE;
                  fire   = 1'b1;
                  kind_r <= bmw_pkg::KIND_ANSWER;
                  bn_r   <= '0;
                end else if (root_valid && root_tag == ptr_d) begin
                  state <= S_RD_ROOT;
                end else begin
                  // refilling the root drops the leaf too
                  state      <= S_IDLE;
                  root_tag   <= ptr_d;
                  root_valid <= 1'b0;
                  leaf_valid <= 1'b0;
                  phase      <= PH_ROOT;
                  fill_count <= '0;
                  pending    <= cur_lb;
                  fire       = 1'b1;
                  kind_r     <= bmw_pkg::KIND_READ;
                  bn_r       <= ptr_d;
                end
              end
              default: begin
                state  <= S_IDLE;
                fire   = 1'b1;
                kind_r <= bmw_pkg::KIND_FAIL;
                bn_r   <= '0;
              end
            endcase
          end
          S_RD_SINGLE: begin
            state  <= S_IDLE;
            fire   = 1'b1;
            kind_r <= bmw_pkg::KIND_ANSWER;
            bn_r   <= single_rdata;
          end
          S_RD_ROOT: begin
            if (root_rdata == '0) begin
              state  <= S_IDLE;
              fire   = 1'b1;
              kind_r <= bmw_pkg::KIND_ANSWER;
              bn_r   <= '0;
            end else if (leaf_valid && leaf_tag == root_rdata) begin
              state <= S_RD_LEAF;
            end else begin
              state      <= S_IDLE;
              leaf_tag   <= root_rdata;
              leaf_valid <= 1'b0;
              phase      <= PH_LEAF;
              fill_count <= '0;
              pending    <= cur_lb;
              fire       = 1'b1;
              kind_r     <= bmw_pkg::KIND_READ;
              bn_r       <= root_rdata;
            end
          end
          S_RD_LEAF: begin
            state  <= S_IDLE;
            fire   = 1'b1;
            kind_r <= bmw_pkg::KIND_ANSWER;
            bn_r   <= leaf_rdata;
          end
          default: state <= S_IDLE;
        endcase
      end
      // hold a stalled result, drop a taken one
      out_valid <= fire || (out_valid && out_stall);
    end
  end

`ifndef ASSERT_OFF
  a_leaf_needs_root: assert property (@(posedge clk) disable iff (rst)
    leaf_valid |-> root_valid) else $error("leaf cache valid without root");
  a_single_fill_invalid: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SINGLE |-> !single_ok) else $error("single cache valid mid-fill");
  a_root_fill_invalid: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ROOT |-> !root_valid && !leaf_valid) else $error("root fill left valid bits");
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> fill_count <= last_idx) else $error("fill count past block end");
`endif

endmodule
`default_nettype wire

// ===== hdl/block_map_walker_with_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_map_walker_with_cache
// Logical to physical block translation with single/double indirect caches.
// ----------------------------------------------------------------------------
// Path: front stage register, queue, then S_TRANS; a cache hit adds one registered
// memory read per level (S_RD_SINGLE, or S_RD_ROOT then S_RD_LEAF).
// The back end takes no new queue item until the walk in hand is back in S_IDLE.
// Reset: synchronous; clears pointer table, tags, valid bits, queue and walk state.
// Cache memories are not cleared; entries are only read after a full fill.
module block_map_walker_with_cache #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    command,
  input  wire logic [3:0]    slot,
  input  wire logic [21:0]   file_block,
  input  wire logic [31:0]   value,
  input  wire logic          read_error,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         kind,
  output logic [31:0]        phys_block
);

  logic            push;
  bmw_pkg::item_t  push_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  bmw_pkg::item_t  q_item;
  logic [1:0]      lbs;
  logic            unsup;

  bmw_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .slot(slot), .file_block(file_block),
    .value(value), .read_error(read_error),
    .lbs(lbs), .unsup(unsup),
    .push(push), .push_item(push_item), .q_full(q_full)
  );

  bmw_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_item(push_item), .full(q_full),
    .not_empty(q_valid), .pop(q_pop), .head(q_item)
  );

  bmw_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .lbs(lbs), .unsup(unsup),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .phys_block(phys_block)
  );

endmodule
`default_nettype wire
